// ----- hdl/dncp_pkg.sv -----
`default_nettype none

package dncp_pkg;

    localparam int unsigned MAX_PATH_LEN_DEFAULT = 4095;
    localparam int unsigned OFFSET_W = 12;
    localparam int unsigned CP_W = 21;

    localparam logic [7:0] BYTE_DOT = 8'h2E;
    localparam logic [7:0] LEAD2_LO = 8'hC2;
    localparam logic [7:0] LEAD2_HI = 8'hDF;
    localparam logic [7:0] LEAD3_LO = 8'hE0;
    localparam logic [7:0] LEAD3_HI = 8'hEF;
    localparam logic [7:0] LEAD4_LO = 8'hF0;
    localparam logic [7:0] LEAD4_HI = 8'hF4;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_3BYTE = 21'h000800;
    localparam logic [CP_W-1:0] MIN_4BYTE = 21'h010000;

    localparam logic [2:0] SEQ_W3 = 3'd3;
    localparam logic [2:0] SEQ_W4 = 3'd4;

    function automatic logic in_range(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                      logic [CP_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_name_start(logic [CP_W-1:0] c);
        return (c == 21'h5F) || in_range(c, 21'h41, 21'h5A) ||
               in_range(c, 21'h61, 21'h7A) ||
               in_range(c, 21'hC0, 21'hD6) || in_range(c, 21'hD8, 21'hF6) ||
               in_range(c, 21'hF8, 21'h2FF) || in_range(c, 21'h370, 21'h37D) ||
               in_range(c, 21'h37F, 21'h1FFF) || in_range(c, 21'h200C, 21'h200D) ||
               in_range(c, 21'h2070, 21'h218F) || in_range(c, 21'h2C00, 21'h2FEF) ||
               in_range(c, 21'h3001, 21'hD7FF) || in_range(c, 21'hF900, 21'hFDCF) ||
               in_range(c, 21'hFDF0, 21'hFFFD) ||
               in_range(c, 21'h10000, 21'hEFFFF);
    endfunction

    function automatic logic is_name_char(logic [CP_W-1:0] c);
        return is_name_start(c) || (c == 21'h2D) || in_range(c, 21'h30, 21'h39) ||
               (c == 21'hB7) || in_range(c, 21'h300, 21'h36F) ||
               in_range(c, 21'h203F, 21'h2040);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/dotted_ncname_path_checker.sv -----
// A path's result passes through the input register and the result register after the
// transfer of its last byte. Throughput: one byte per cycle unless the input stalls;
// the decode state update is a single combinational step.
// The input stalls only while a finished result waits in a stalled result register.
// Reset (rst_n, asynchronous, active low) clears both valid flags and all decode state.
`default_nettype none

module dotted_ncname_path_checker #(
    parameter int unsigned MAX_PATH_LEN = dncp_pkg::MAX_PATH_LEN_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    path_byte,
    input  wire logic                          last_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               path_ok,
    output logic [dncp_pkg::OFFSET_W-1:0]      error_offset
);
    import dncp_pkg::*;

    localparam int unsigned CAP_INT = (MAX_PATH_LEN < 4095) ? MAX_PATH_LEN : 4095;
    localparam logic [OFFSET_W:0] OFFSET_CAP = (OFFSET_W+1)'(CAP_INT);

    logic                in_valid_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;

    logic                seg_start_reg, seg_start_next;
    logic [1:0]          expect_reg, expect_next;
    logic [2:0]          seq_width_reg, seq_width_next;
    logic [CP_W-1:0]     accum_reg, accum_next;
    logic [OFFSET_W-1:0] cp_offset_reg, cp_offset_next;
    logic [OFFSET_W-1:0] position_reg, position_next;
    logic                error_reg, error_next;
    logic [OFFSET_W-1:0] error_offset_reg, error_offset_next;

    logic                out_valid_reg;
    logic                path_ok_reg, path_ok_next;
    logic [OFFSET_W-1:0] result_offset_reg, result_offset_next;

    logic                out_free;
    logic                stage_fire;
    logic                in_take;

    assign out_free   = !out_valid_reg || !out_stall;
    assign stage_fire = in_valid_reg && (!last_reg || out_free);
    assign in_stall   = in_valid_reg && !stage_fire;
    assign in_take    = in_valid && !in_stall;

    assign out_valid    = out_valid_reg;
    assign path_ok      = path_ok_reg;
    assign error_offset = result_offset_reg;

    always_comb
    begin
        logic [OFFSET_W:0]   pos_inc;
        logic [OFFSET_W-1:0] length;
        logic [CP_W-1:0]     cp;
        logic                cp_done;
        logic                name_ok;

        seg_start_next    = seg_start_reg;
        expect_next       = expect_reg;
        seq_width_next    = seq_width_reg;
        accum_next        = accum_reg;
        cp_offset_next    = cp_offset_reg;
        error_next        = error_reg;
        error_offset_next = error_offset_reg;
        cp                = {13'd0, byte_reg};
        cp_done           = 1'b0;
        name_ok           = 1'b0;

        pos_inc = {1'b0, position_reg} + 1'b1;
        length  = (pos_inc > OFFSET_CAP) ? OFFSET_CAP[OFFSET_W-1:0]
                                         : pos_inc[OFFSET_W-1:0];

        if (!error_reg)
        begin
            if (expect_reg == 2'd0)
            begin
                cp_offset_next = position_reg;
                if (byte_reg == BYTE_DOT)
                begin
                    if (seg_start_reg)
                    begin
                        error_next        = 1'b1;
                        error_offset_next = position_reg;
                    end
                    else
                    begin
                        seg_start_next = 1'b1;
                    end
                end
                else if (!byte_reg[7])
                begin
                    cp_done = 1'b1;
                end
                else if (byte_reg >= LEAD2_LO && byte_reg <= LEAD2_HI)
                begin
                    seq_width_next = 3'd2;
                    expect_next    = 2'd1;
                    accum_next     = {16'd0, byte_reg[4:0]};
                end
                else if (byte_reg >= LEAD3_LO && byte_reg <= LEAD3_HI)
                begin
                    seq_width_next = SEQ_W3;
                    expect_next    = 2'd2;
                    accum_next     = {17'd0, byte_reg[3:0]};
                end
                else if (byte_reg >= LEAD4_LO && byte_reg <= LEAD4_HI)
                begin
                    seq_width_next = SEQ_W4;
                    expect_next    = 2'd3;
                    accum_next     = {18'd0, byte_reg[2:0]};
                end
                else
                begin
                    error_next        = 1'b1;
                    error_offset_next = position_reg;
                end
            end
            else if (byte_reg[7:6] != 2'b10)
            begin
                error_next        = 1'b1;
                error_offset_next = cp_offset_reg;
            end
            else
            begin
                cp          = {accum_reg[CP_W-7:0], byte_reg[5:0]};
                accum_next  = cp;
                expect_next = expect_reg - 2'd1;
                if (expect_next == 2'd0)
                begin
                    if ((seq_width_reg == SEQ_W3 && cp < MIN_3BYTE) ||
                        (seq_width_reg == SEQ_W4 && cp < MIN_4BYTE) ||
                        (cp >= SURR_LO && cp <= SURR_HI) || cp > CP_MAX)
                    begin
                        error_next        = 1'b1;
                        error_offset_next = cp_offset_reg;
                    end
                    else
                    begin
                        cp_done = 1'b1;
                    end
                end
            end

            if (cp_done)
            begin
                name_ok = seg_start_reg ? is_name_start(cp) : is_name_char(cp);
                if (name_ok)
                begin
                    seg_start_next = 1'b0;
                end
                else
                begin
                    error_next        = 1'b1;
                    error_offset_next = cp_offset_next;
                end
            end
        end

        position_next = length;

        if (!error_next)
        begin
            if (expect_next != 2'd0)
            begin
                path_ok_next       = 1'b0;
                result_offset_next = cp_offset_next;
            end
            else if (seg_start_next)
            begin
                path_ok_next       = 1'b0;
                result_offset_next = length;
            end
            else
            begin
                path_ok_next       = 1'b1;
                result_offset_next = '0;
            end
        end
        else
        begin
            path_ok_next       = 1'b0;
            result_offset_next = error_offset_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (stage_fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg <= path_byte;
            last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_start_reg    <= 1'b1;
            expect_reg       <= 2'd0;
            seq_width_reg    <= 3'd0;
            accum_reg        <= '0;
            cp_offset_reg    <= '0;
            position_reg     <= '0;
            error_reg        <= 1'b0;
            error_offset_reg <= '0;
        end
        else if (stage_fire)
        begin
            if (last_reg)
            begin
                seg_start_reg    <= 1'b1;
                expect_reg       <= 2'd0;
                seq_width_reg    <= 3'd0;
                accum_reg        <= '0;
                cp_offset_reg    <= '0;
                position_reg     <= '0;
                error_reg        <= 1'b0;
                error_offset_reg <= '0;
            end
            else
            begin
                seg_start_reg    <= seg_start_next;
                expect_reg       <= expect_next;
                seq_width_reg    <= seq_width_next;
                accum_reg        <= accum_next;
                cp_offset_reg    <= cp_offset_next;
                position_reg     <= position_next;
                error_reg        <= error_next;
                error_offset_reg <= error_offset_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && last_reg)
        begin
            path_ok_reg       <= path_ok_next;
            result_offset_reg <= result_offset_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/dncp_checker.sv -----
`default_nettype none

module dncp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic [7:0]                    path_byte,
    input wire logic                          last_byte,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          path_ok,
    input wire logic [dncp_pkg::OFFSET_W-1:0] error_offset
);
    import dncp_pkg::*;

    // A passing path always reports offset zero.
    a_ok_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_ok |-> error_offset == '0)
        else $error("passing result with nonzero offset");

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a pending result");

    // The transfer of a last byte yields a result through the input and result registers if the output drains.
    a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) ##1 !out_stall |=> out_valid)
        else $error("result missing after last byte");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(path_ok) && $stable(error_offset))
        else $error("stalled result changed");

endmodule

bind dotted_ncname_path_checker dncp_checker u_dncp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .path_byte    (path_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .path_ok      (path_ok),
    .error_offset (error_offset)
);

`default_nettype wire

// ----- bench/dotted_ncname_path_checker_tb.sv -----
`default_nettype none

module dotted_ncname_path_checker_tb;

    import dncp_pkg::*;

    localparam int PATH_CAP = (MAX_PATH_LEN_DEFAULT < 4095) ? int'(MAX_PATH_LEN_DEFAULT) : 4095;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_BYTES = 520;

    localparam logic [CP_W-1:0] EDGE_CPS [40] = '{
        21'h00002D, 21'h00002F, 21'h000030, 21'h000039, 21'h00003A,
        21'h000040, 21'h00005B, 21'h000060, 21'h00007B, 21'h00007F,
        21'h0000B7, 21'h0000C0, 21'h0000D6, 21'h0000D7, 21'h0000F6,
        21'h0000F7, 21'h0002FF, 21'h000300, 21'h00036F, 21'h00037D,
        21'h00037E, 21'h001FFF, 21'h00200B, 21'h00200C, 21'h00203F,
        21'h002041, 21'h00218F, 21'h002C00, 21'h002FEF, 21'h003000,
        21'h00D7FF, 21'h00F8FF, 21'h00FDCF, 21'h00FDD0, 21'h00FFFD,
        21'h00FFFE, 21'h0EFFFF, 21'h0F0000, 21'h10FFFF, 21'h000000
    };

    typedef struct packed {
        logic                ok;
        logic [OFFSET_W-1:0] offset;
    } verdict_t;

    typedef logic [7:0] byte_seq_t [$];

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          path_byte = 8'h00;
    logic                last_byte = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                path_ok;
    logic [OFFSET_W-1:0] error_offset;

    verdict_t            expected_verdicts [$];
    logic [7:0]          path_buf [$];

    logic                seg_start;
    logic [1:0]          cont_left;
    logic [2:0]          seq_len;
    logic [CP_W-1:0]     cp_acc;
    logic [OFFSET_W-1:0] cp_off;
    logic [OFFSET_W-1:0] pos_now;
    logic                err_hit;
    logic [OFFSET_W-1:0] err_off;

    bit                  gaps_on = 1'b0;
    logic                stall_on = 1'b0;
    int                  stall_left = 0;
    int                  stall_roll;
    int                  quiet_cycles = 0;
    int                  mismatches = 0;
    int                  byte_total = 0;
    int                  path_total = 0;
    int                  ok_seen = 0;
    int                  rejected_seen = 0;

    dotted_ncname_path_checker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .path_byte    (path_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .path_ok      (path_ok),
        .error_offset (error_offset)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit in_band(logic [CP_W-1:0] c, int lo, int hi);
        return (int'(c) >= lo) && (int'(c) <= hi);
    endfunction

    function automatic bit ncname_head(logic [CP_W-1:0] c);
        return c == 21'h5F || in_band(c, 'h41, 'h5A) || in_band(c, 'h61, 'h7A) ||
               in_band(c, 'hC0, 'hD6) || in_band(c, 'hD8, 'hF6) ||
               in_band(c, 'hF8, 'h2FF) || in_band(c, 'h370, 'h37D) ||
               in_band(c, 'h37F, 'h1FFF) || in_band(c, 'h200C, 'h200D) ||
               in_band(c, 'h2070, 'h218F) || in_band(c, 'h2C00, 'h2FEF) ||
               in_band(c, 'h3001, 'hD7FF) || in_band(c, 'hF900, 'hFDCF) ||
               in_band(c, 'hFDF0, 'hFFFD) || in_band(c, 'h10000, 'hEFFFF);
    endfunction

    function automatic bit ncname_tail(logic [CP_W-1:0] c);
        return ncname_head(c) || c == 21'h2D || in_band(c, 'h30, 'h39) ||
               c == 21'hB7 || in_band(c, 'h300, 'h36F) || in_band(c, 'h203F, 'h2040);
    endfunction

    task automatic clear_tracker();
        seg_start = 1'b1;
        cont_left = 2'd0;
        seq_len = 3'd0;
        cp_acc = '0;
        cp_off = '0;
        pos_now = '0;
        err_hit = 1'b0;
        err_off = '0;
    endtask

    task automatic flag_error(input logic [OFFSET_W-1:0] where_at);
        if (!err_hit)
        begin
            err_hit = 1'b1;
            err_off = where_at;
        end
    endtask

    task automatic take_code_point(input logic [CP_W-1:0] c);
        if (seg_start ? ncname_head(c) : ncname_tail(c))
            seg_start = 1'b0;
        else
            flag_error(cp_off);
    endtask

    task automatic predict_path_byte(input logic [7:0] b, input logic fin);
        logic [OFFSET_W-1:0] here;
        logic [OFFSET_W-1:0] span;
        logic [CP_W-1:0]     v;
        verdict_t            res;
        here = pos_now;
        span = (int'(here) + 1 > PATH_CAP) ? OFFSET_W'(PATH_CAP) : here + 1'b1;
        if (!err_hit)
        begin
            if (cont_left == 2'd0)
            begin
                cp_off = here;
                if (b == BYTE_DOT)
                begin
                    if (seg_start)
                        flag_error(here);
                    else
                        seg_start = 1'b1;
                end
                else if (b < 8'h80)
                    take_code_point(CP_W'(b));
                else if (b >= LEAD2_LO && b <= LEAD2_HI)
                begin
                    seq_len = 3'd2;
                    cont_left = 2'd1;
                    cp_acc = CP_W'(b[4:0]);
                end
                else if (b >= LEAD3_LO && b <= LEAD3_HI)
                begin
                    seq_len = SEQ_W3;
                    cont_left = 2'd2;
                    cp_acc = CP_W'(b[3:0]);
                end
                else if (b >= LEAD4_LO && b <= LEAD4_HI)
                begin
                    seq_len = SEQ_W4;
                    cont_left = 2'd3;
                    cp_acc = CP_W'(b[2:0]);
                end
                else
                    flag_error(here);
            end
            else if (b[7:6] != 2'b10)
                flag_error(cp_off);
            else
            begin
                v = {cp_acc[14:0], b[5:0]};
                cp_acc = v;
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    if ((seq_len == SEQ_W3 && v < MIN_3BYTE) ||
                        (seq_len == SEQ_W4 && v < MIN_4BYTE) ||
                        (v >= SURR_LO && v <= SURR_HI) || v > CP_MAX)
                        flag_error(cp_off);
                    else
                        take_code_point(v);
                end
            end
        end
        pos_now = span;
        if (fin)
        begin
            if (!err_hit)
            begin
                if (cont_left != 2'd0)
                    flag_error(cp_off);
                else if (seg_start)
                    flag_error(span);
            end
            res.ok = !err_hit;
            res.offset = err_hit ? err_off : '0;
            expected_verdicts.push_back(res);
            path_total++;
            clear_tracker();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            path_byte <= 8'($urandom);
            last_byte <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        path_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_path_byte(b, fin);
        byte_total++;
    endtask

    task automatic send_path();
        for (int i = 0; i < path_buf.size(); i++)
            send_byte(path_buf[i], i == path_buf.size() - 1);
    endtask

    task automatic send_seq(input byte_seq_t s);
        path_buf = s;
        send_path();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_verdicts.size() != 0);
    endtask

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    task automatic put_utf8(input logic [CP_W-1:0] c);
        if (c < 21'h80)
            path_buf.push_back(c[7:0]);
        else if (c < 21'h800)
        begin
            path_buf.push_back({3'b110, c[10:6]});
            path_buf.push_back({2'b10, c[5:0]});
        end
        else if (c < 21'h10000)
        begin
            path_buf.push_back({4'b1110, c[15:12]});
            path_buf.push_back({2'b10, c[11:6]});
            path_buf.push_back({2'b10, c[5:0]});
        end
        else
        begin
            path_buf.push_back({5'b11110, c[20:18]});
            path_buf.push_back({2'b10, c[17:12]});
            path_buf.push_back({2'b10, c[11:6]});
            path_buf.push_back({2'b10, c[5:0]});
        end
    endtask

    function automatic logic [CP_W-1:0] pick_name_cp(bit head);
        logic [CP_W-1:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: c = CP_W'($urandom_range('h61, 'h7A));
            3: c = CP_W'($urandom_range('h41, 'h5A));
            4: c = head ? 21'h5F : CP_W'($urandom_range('h30, 'h39));
            5: c = head ? 21'h5F : 21'h2D;
            6: c = CP_W'($urandom_range('hF8, 'h2FF));
            7: c = CP_W'($urandom_range('h3001, 'hD7FF));
            8: c = CP_W'($urandom_range('h10000, 'hEFFFF));
            9: c = head ? CP_W'($urandom_range('h37F, 'h1FFF))
                        : CP_W'($urandom_range('h300, 'h36F));
            10: c = EDGE_CPS[$urandom_range(0, 39)];
            default:
            begin
                c = CP_W'($urandom_range(0, 'h10FFFF));
                if (c >= SURR_LO && c <= SURR_HI)
                    c = 21'h23;
            end
        endcase
        return c;
    endfunction

    task automatic put_flaw();
        case ($urandom_range(0, 8))
            0:
            begin
                path_buf.push_back(8'($urandom_range('hC0, 'hC1)));
                path_buf.push_back(cont_byte());
            end
            1:
            begin
                path_buf.push_back(8'hE0);
                path_buf.push_back(8'($urandom_range('h80, 'h9F)));
                path_buf.push_back(cont_byte());
            end
            2:
            begin
                path_buf.push_back(8'hF0);
                path_buf.push_back(8'($urandom_range('h80, 'h8F)));
                path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            3:
            begin
                path_buf.push_back(8'hED);
                path_buf.push_back(8'($urandom_range('hA0, 'hBF)));
                path_buf.push_back(cont_byte());
            end
            4:
            begin
                path_buf.push_back(8'hF4);
                path_buf.push_back(8'($urandom_range('h90, 'hBF)));
                path_buf.push_back(cont_byte());
                path_buf.push_back(cont_byte());
            end
            5: path_buf.push_back(8'($urandom_range('h80, 'hBF)));
            6: path_buf.push_back(8'($urandom_range('hF5, 'hFF)));
            7:
            begin
                path_buf.push_back(8'($urandom_range(LEAD2_LO, LEAD4_HI)));
                path_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range('h00, 'h7F))
                                                        : 8'($urandom_range('hC0, 'hFF)));
            end
            default: path_buf.push_back(BYTE_DOT);
        endcase
    endtask

    task automatic build_random_path();
        int         kind;
        int         segs;
        int         cps;
        int         w;
        bit         dirty;
        logic [7:0] lead;
        path_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 10))
                path_buf.push_back(8'($urandom));
            return;
        end
        dirty = kind >= 70;
        segs = $urandom_range(1, 4);
        for (int s = 0; s < segs; s++)
        begin
            if (s > 0)
                path_buf.push_back(BYTE_DOT);
            cps = $urandom_range(1, 6);
            for (int c = 0; c < cps; c++)
            begin
                if (dirty && $urandom_range(0, 9) == 0)
                    put_flaw();
                else
                    put_utf8(pick_name_cp(c == 0));
            end
        end
        if (dirty)
        begin
            case ($urandom_range(0, 5))
                0: path_buf.push_back(BYTE_DOT);
                1:
                begin
                    lead = 8'($urandom_range(LEAD2_LO, LEAD4_HI));
                    w = (lead >= LEAD4_LO) ? 4 : (lead >= LEAD3_LO) ? 3 : 2;
                    path_buf.push_back(lead);
                    repeat ($urandom_range(0, w - 2))
                        path_buf.push_back(cont_byte());
                end
                2: path_buf[$urandom_range(0, path_buf.size() - 1)] = 8'($urandom);
                default: ;
            endcase
        end
    endtask

    task automatic test_directed_cases();
        gaps_on = 1'b1;
        stall_on <= 1'b1;
        send_seq({8'h61});
        send_seq({8'h61, 8'h2E, 8'h62, 8'h5F, 8'h63, 8'h2D, 8'h39});
        send_seq({8'h2E, 8'h61});
        send_seq({8'h61, 8'h2E, 8'h2E, 8'h62});
        send_seq({8'h61, 8'h2E});
        send_seq({8'h2E});
        send_seq({8'h39, 8'h61});
        send_seq({8'h00});
        send_seq({8'h61, 8'h80});
        send_seq({8'hC1, 8'hBF});
        send_seq({8'hF5, 8'h80, 8'h80, 8'h80});
        send_seq({8'hFF});
        send_seq({8'hE0, 8'h9F, 8'hBF});
        send_seq({8'hF0, 8'h8F, 8'hBF, 8'hBF});
        send_seq({8'hED, 8'hA0, 8'h80});
        send_seq({8'hF4, 8'h90, 8'h80, 8'h80});
        send_seq({8'h61, 8'hC3});
        send_seq({8'h61, 8'hE2, 8'h82});
        send_seq({8'hC3, 8'h28});
        send_seq({8'h61, 8'hC3, 8'h2E, 8'h62});
        send_seq({8'hF3, 8'hAF, 8'hBF, 8'hBF});
        send_seq({8'h61, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
        send_seq({8'hCC, 8'h80});
        send_seq({8'h61, 8'hCC, 8'h80, 8'hC2, 8'hB7, 8'hE2, 8'h80, 8'hBF});
        send_seq({8'hEF, 8'hBF, 8'hBD, 8'h2E, 8'hC3, 8'h80, 8'hE3, 8'h80, 8'h81});
        send_seq({8'h39, 8'h2E, 8'h2E, 8'hFF});
        wait_drained();
    endtask

    task automatic test_random_paths();
        int start_bytes;
        int paths;
        start_bytes = byte_total;
        paths = 0;
        while (byte_total - start_bytes < RANDOM_BYTES)
        begin
            if (paths % 8 == 0)
            begin
                gaps_on = $urandom_range(0, 3) != 0;
                stall_on <= $urandom_range(0, 3) != 0;
            end
            build_random_path();
            send_path();
            paths++;
        end
        wait_drained();
    endtask

    task automatic test_drain_pauses();
        gaps_on = 1'b1;
        stall_on <= 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            build_random_path();
            send_path();
            if (i % 2 == 1)
                wait_drained();
        end
    endtask

    always @(posedge clk)
    begin
        if (!stall_on)
            out_stall <= 1'b0;
        else if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                out_stall <= 1'b0;
            else
            begin
                out_stall <= 1'b1;
                stall_left <= (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result path_ok=%0b error_offset=%0d",
                         $time, path_ok, error_offset);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (path_ok)
                    ok_seen++;
                else
                    rejected_seen++;
                if (path_ok !== want.ok)
                begin
                    mismatches++;
                    $display("%0t: path_ok expected %0b, actual %0b", $time, want.ok, path_ok);
                end
                if (error_offset !== want.offset)
                begin
                    mismatches++;
                    $display("%0t: error_offset expected %0d, actual %0d",
                             $time, want.offset, error_offset);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clear_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_paths();
        test_drain_pauses();
        repeat (8) @(posedge clk);
        $display("Checked %0d paths over %0d bytes: %0d accepted, %0d rejected.",
                 path_total, byte_total, ok_seen, rejected_seen);
        $display("Covered strict UTF-8 decoding, name character classes and empty segments.");
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
